// ===== design/asch_pkg.sv =====
// Shared types, constants and the permutation round for the sponge hash.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package asch_pkg;

  localparam int unsigned QDEPTH = 2;

  localparam logic [1:0] VARIANT_HASH256 = 2'd0;
  localparam logic [1:0] VARIANT_HASH    = 2'd1;
  localparam logic [1:0] VARIANT_HASHA   = 2'd2;

  localparam logic [63:0] IV_HASH256 = 64'h0000_0801_00cc_0002;
  localparam logic [63:0] IV_HASH    = 64'h0000_0801_00cc_0010;
  localparam logic [63:0] IV_HASHA   = 64'h0000_0801_00cc_0011;

  // Padding byte at the head of an otherwise empty word
  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

  typedef logic [4:0][63:0] lanes_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PERM,
    BK_SQUEEZE
  } back_state_e;

  // One classified message word as it travels from front to back
  typedef struct packed {
    logic        start;      // first word of a message: load IV first
    logic [1:0]  variant;
    logic [63:0] word;       // word to absorb; a short last word is already masked and padded
    logic        extra_pad;  // absorb a lone padding word afterwards
    logic        fin;        // squeeze after the last absorb
  } entry_t;

  function automatic logic [63:0] iv_of(logic [1:0] variant);
    logic [63:0] iv;
    case (variant)
      VARIANT_HASH:  iv = IV_HASH;
      VARIANT_HASHA: iv = IV_HASHA;
      default:       iv = IV_HASH256;
    endcase
    return iv;
  endfunction

  function automatic logic [63:0] rotr(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic lanes_t ascon_round(lanes_t s, logic [7:0] rc);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {56'd0, rc};
    x3 = s[3];
    x4 = s[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    s[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    s[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    s[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
    s[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    s[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/asch_front.sv =====
// Front end: accepts message words, tracks message start and builds padded entries.
// Depends on asch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asch_front import asch_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  variant_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_word_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output entry_t           push_entry_o
);

  logic        open_q, open_d;
  logic        full_word;
  logic [5:0]  shamt;
  logic [63:0] keep;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // counts of eight and above absorb the whole word
  assign full_word = byte_count_i[3];
  assign shamt     = {byte_count_i[2:0], 3'b000};
  assign keep      = ~({64{1'b1}} >> shamt);

  always_comb begin
    push_entry_o.start     = !open_q;
    push_entry_o.variant   = variant_i;
    push_entry_o.extra_pad = 1'b0;
    push_entry_o.fin       = last_word_i;
    if (!last_word_i) begin
      push_entry_o.word = data_word_i;
    end else if (full_word) begin
      push_entry_o.word      = data_word_i;
      push_entry_o.extra_pad = 1'b1;
    end else begin
      push_entry_o.word = (data_word_i & keep) | (PAD_WORD >> shamt);
    end
  end

  always_comb begin
    open_d = open_q;
    if (push_o) begin
      open_d = !last_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/asch_queue.sv =====
// Short FIFO of classified entries between front and back.
// Depends on asch_pkg for entry_t and QDEPTH.
`timescale 1ns / 1ps
`default_nettype none

module asch_queue import asch_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      head_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  entry_t          mem_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_pop;

  assign full_o  = (count_q == CW'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/asch_back.sv =====
// Back end: sponge state, one permutation round per cycle, squeeze into an
// output register. Depends on asch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asch_back import asch_pkg::*; #(
  parameter int unsigned ROUNDS       = 12,
  parameter int unsigned DIGEST_WORDS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire entry_t      q_head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic             digest_last_o
);

  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned KW = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;
  localparam logic [3:0]  RSTART = 4'(12 - ROUNDS);

  back_state_e     state_q, state_d;
  logic [RW-1:0]   rnd_q, rnd_d;
  logic [KW-1:0]   k_q, k_d;
  logic            need_absorb_q, need_absorb_d;
  logic            need_pad_q, need_pad_d;
  logic            fin_q, fin_d;
  logic [63:0]     word_q, word_d;
  lanes_t          lanes_q, lanes_d;
  lanes_t          round_out, base;
  logic [3:0]      ridx;
  logic            last_rnd;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_word_q;
  logic            out_last_q;
  logic            out_load;

  assign ridx      = RSTART + 4'(rnd_q);
  assign round_out = ascon_round(lanes_q, {~ridx, ridx});
  assign last_rnd  = (rnd_q == RW'(ROUNDS - 1));
  assign base      = (state_q == BK_IDLE) ? lanes_q : round_out;

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign digest_last_o = out_last_q;

  always_comb begin
    state_d       = state_q;
    rnd_d         = rnd_q;
    k_d           = k_q;
    need_absorb_d = need_absorb_q;
    need_pad_d    = need_pad_q;
    fin_d         = fin_q;
    word_d        = word_q;
    lanes_d       = lanes_q;
    pop_o         = 1'b0;
    out_load      = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;

    case (state_q)
      BK_IDLE: begin
        pop_o = q_valid_i;
      end
      BK_PERM: begin
        lanes_d = round_out;
        rnd_d   = rnd_q + 1'b1;
        if (last_rnd) begin
          rnd_d = '0;
          if (need_absorb_q) begin
            lanes_d[0]    = round_out[0] ^ word_q;
            need_absorb_d = 1'b0;
          end else if (need_pad_q) begin
            lanes_d[0] = round_out[0] ^ PAD_WORD;
            need_pad_d = 1'b0;
          end else if (fin_q) begin
            state_d = BK_SQUEEZE;
          end else if (q_valid_i) begin
            pop_o = 1'b1;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_SQUEEZE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (k_q == KW'(DIGEST_WORDS - 1)) begin
            k_d     = '0;
            fin_d   = 1'b0;
            state_d = BK_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = BK_PERM;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // take the next entry straight from the queue head
    if (pop_o) begin
      state_d    = BK_PERM;
      rnd_d      = '0;
      need_pad_d = q_head_i.extra_pad;
      fin_d      = q_head_i.fin;
      word_d     = q_head_i.word;
      if (q_head_i.start) begin
        lanes_d       = '0;
        lanes_d[0]    = iv_of(q_head_i.variant);
        need_absorb_d = 1'b1;
      end else begin
        lanes_d       = base;
        lanes_d[0]    = base[0] ^ q_head_i.word;
        need_absorb_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BK_IDLE;
      rnd_q         <= '0;
      k_q           <= '0;
      need_absorb_q <= 1'b0;
      need_pad_q    <= 1'b0;
      fin_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rnd_q         <= rnd_d;
      k_q           <= k_d;
      need_absorb_q <= need_absorb_d;
      need_pad_q    <= need_pad_d;
      fin_q         <= fin_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    word_q  <= word_d;
    if (out_load) begin
      out_word_q <= lanes_q[0];
      out_last_q <= (k_q == KW'(DIGEST_WORDS - 1));
    end
  end

  a_rnd_only_in_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_q != '0) |-> (state_q == BK_PERM))
    else $error("round counter running outside a permutation");

  a_squeeze_needs_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SQUEEZE) |-> fin_q)
    else $error("squeezing without a finished message");

  a_pending_absorb_in_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_absorb_q || need_pad_q) |-> (state_q == BK_PERM))
    else $error("pending absorb while not permuting");

  a_last_digest_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (k_q == KW'(DIGEST_WORDS - 1))) |=> (state_q == BK_IDLE) && !fin_q)
    else $error("squeeze did not close after the final digest beat");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== design/ascon_sponge_hash.sv =====
// Top level of the sponge hash: variant register, front end, queue, back end.
// Depends on asch_pkg, asch_front, asch_queue and asch_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  cfg     | cfg_we_i              | cfg_data_i (variant)
//  in      | in_valid_i/in_stall_o | data_word_i, byte_count_i, last_word_i
//  out     | out_valid_o/out_stall_i | digest_word_o, digest_last_o
//
// Each absorbed word goes through a permutation of ROUNDS rounds in the
// one-round-per-cycle permutation unit; the first word of a message adds an
// IV permutation and a full last word adds a permutation for the padding word.
// Squeeze: each digest beat is loaded into the output register once it is free,
// with a permutation of ROUNDS rounds between beats.
// Reset clears control state only; the sponge lanes are loaded at message start.
// The queue keeps taking beats, until it is full, while the back end permutes or waits on out_stall_i.
`timescale 1ns / 1ps
`default_nettype none

module ascon_sponge_hash import asch_pkg::*; #(
  parameter int unsigned ROUNDS       = 12,
  parameter int unsigned DIGEST_WORDS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic             digest_last_o
);

  logic [1:0] variant_q, variant_d;
  logic       q_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       q_valid;
  entry_t     q_head;

  assign variant_d = cfg_we_i ? cfg_data_i : variant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VARIANT_HASH256;
    end else begin
      variant_q <= variant_d;
    end
  end

  asch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .variant_i    (variant_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  asch_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  asch_back #(
    .ROUNDS       (ROUNDS),
    .DIGEST_WORDS (DIGEST_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o)
  );

endmodule

`default_nettype wire

// ===== tb/ascon_sponge_hash_checker.sv =====
// Scoreboard for the sponge hash: mirrors the variant register, absorbs every accepted
// word, predicts each message's digest beats and compares each accepted beat in order.
// Depends on asch_pkg for the variant codes, IVs and the padding word.
`timescale 1ns / 1ps

module ascon_sponge_hash_checker import asch_pkg::*; #(
  parameter int unsigned ROUNDS       = 12,
  parameter int unsigned DIGEST_WORDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] digest_word_i,
  input  logic        digest_last_i,
  output int unsigned mismatches_o,
  output int unsigned words_due_o
);

  typedef logic [4:0][63:0] sponge_t;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_t;

  // Spare code 3 falls back to the hash256 IV
  localparam logic [63:0] IV_BY_CODE [4] = '{IV_HASH256, IV_HASH, IV_HASHA, IV_HASH256};

  sponge_t     sponge;
  logic        msg_open;
  logic [1:0]  variant_q;
  digest_t     digests_due [$];
  int unsigned mismatches;

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    logic [127:0] twice;
    twice = {x, x} >> n;
    return twice[63:0];
  endfunction

  function automatic sponge_t sponge_permute(sponge_t s);
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] c0, c1, c2, c3, c4;
    int r;
    a0 = s[0];
    a1 = s[1];
    a2 = s[2];
    a3 = s[3];
    a4 = s[4];
    for (r = 12 - int'(ROUNDS); r < 12; r++) begin
      a2 = a2 ^ 64'((((15 - r) & 15) << 4) | (r & 15));
      a0 = a0 ^ a4;
      a4 = a4 ^ a3;
      a2 = a2 ^ a1;
      c0 = ~a0 & a1;
      c1 = ~a1 & a2;
      c2 = ~a2 & a3;
      c3 = ~a3 & a4;
      c4 = ~a4 & a0;
      a0 = a0 ^ c1;
      a1 = a1 ^ c2;
      a2 = a2 ^ c3;
      a3 = a3 ^ c4;
      a4 = a4 ^ c0;
      a1 = a1 ^ a0;
      a0 = a0 ^ a4;
      a3 = a3 ^ a2;
      a2 = ~a2;
      a0 = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
      a1 = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
      a2 = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
      a3 = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
      a4 = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
    end
    return {a4, a3, a2, a1, a0};
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Absorb one message word; on the last word queue the digest beats it yields
  task automatic take_word(logic [63:0] data, logic [3:0] count, logic fin);
    int          n;
    int          k;
    logic [63:0] keep;
    digest_t     beat;
    if (!msg_open) begin
      sponge    = '0;
      sponge[0] = IV_BY_CODE[variant_q];
      sponge    = sponge_permute(sponge);
      msg_open  = 1'b1;
    end
    n = (count > 4'd8) ? 8 : int'(count);
    if (!fin) begin
      sponge[0] = sponge[0] ^ data;
      sponge    = sponge_permute(sponge);
    end else begin
      // a full last word is absorbed whole and followed by a lone padding word
      if (n == 8) begin
        sponge[0] = sponge[0] ^ data;
        sponge    = sponge_permute(sponge);
        n         = 0;
      end
      keep      = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
      sponge[0] = sponge[0] ^ (data & keep) ^ (PAD_WORD >> (8 * n));
      sponge    = sponge_permute(sponge);
      for (k = 0; k < int'(DIGEST_WORDS); k++) begin
        beat.word = sponge[0];
        beat.last = (k == int'(DIGEST_WORDS) - 1);
        digests_due.push_back(beat);
        if (k != int'(DIGEST_WORDS) - 1) sponge = sponge_permute(sponge);
      end
      msg_open = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_t want;
    if (!rst_ni) begin
      sponge     = '0;
      msg_open   = 1'b0;
      variant_q  = VARIANT_HASH256;
      mismatches = 0;
      digests_due.delete();
    end else begin
      if (cfg_we_i) variant_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) take_word(data_word_i, byte_count_i, last_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (digests_due.size() == 0) begin
          report_mismatch("digest beat with none due", digest_word_i, 64'd0);
        end else begin
          want = digests_due.pop_front();
          if (digest_word_i !== want.word) report_mismatch("digest_word", digest_word_i, want.word);
          if (digest_last_i !== want.last) begin
            report_mismatch("digest_last", 64'(digest_last_i), 64'(want.last));
          end
        end
      end
    end
    // publish after the edge so the stimulus side never races the update
    mismatches_o <= mismatches;
    words_due_o  <= digests_due.size();
  end

endmodule

// ===== tb/ascon_sponge_hash_test.sv =====
// Top of the sponge hash testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on asch_pkg, the ascon_sponge_hash block and ascon_sponge_hash_checker.
`timescale 1ns / 1ps

module ascon_sponge_hash_test import asch_pkg::*;;

  localparam int unsigned ROUNDS         = 12;
  localparam int unsigned DIGEST_WORDS   = 4;
  localparam int          ITEM_TARGET    = 260;
  localparam int          DRAIN_CYCLES   = 3 * ROUNDS + 8;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 3000;

  localparam logic [1:0]  VARIANT_SPARE  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] data_word_i;
  logic [3:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_word_o;
  logic        digest_last_o;

  logic        rx_busy;
  logic        rx_hold;
  bit          hold_go;
  bit          tx_eager;
  int          words_sent;
  int unsigned mismatch_count;
  int unsigned words_due;

  assign out_stall_i = rx_busy | rx_hold;

  ascon_sponge_hash #(
    .ROUNDS      (ROUNDS),
    .DIGEST_WORDS(DIGEST_WORDS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .digest_last_o(digest_last_o)
  );

  ascon_sponge_hash_checker #(
    .ROUNDS      (ROUNDS),
    .DIGEST_WORDS(DIGEST_WORDS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_i(digest_word_o),
    .digest_last_i(digest_last_o),
    .mismatches_o (mismatch_count),
    .words_due_o  (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Digest side: random pause per beat, with stretches of eager acceptance
  initial begin
    int pause;
    int run_left;
    bit eager;
    rx_busy  = 1'b0;
    run_left = 0;
    eager    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (run_left == 0) begin
        eager    = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(8, 24);
      end
      run_left--;
      pause = eager ? 0 : $urandom_range(0, 14);
      if (pause > 0) begin
        rx_busy <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      rx_busy <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Long hold on the digest side so the block backs up into its input
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog: give up after too many cycles without any beat or register write
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one message word; valid stays high after acceptance for back-to-back beats
  task automatic push_word(input logic [63:0] data, input logic [3:0] count, input logic fin);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_word_i  <= data;
    byte_count_i <= count;
    last_word_i  <= fin;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic wait_all_digests();
    do @(posedge clk_i); while (words_due != 0);
  endtask

  task automatic set_variant(input logic [1:0] code);
    wait_all_digests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_data_i <= code;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly full 8-byte words then a proper tail; now and then odd counts
  task automatic random_message();
    int         len;
    int         k;
    logic [3:0] count;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    for (k = 0; k < len; k++) begin
      count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      push_word({$urandom, $urandom}, count, 1'b0);
    end
    count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    push_word({$urandom, $urandom}, count, 1'b1);
  endtask

  initial begin
    int         phase;
    int         msgs;
    logic [1:0] code;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = VARIANT_HASH256;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_word_i  = 1'b0;
    hold_go      = 1'b0;
    tx_eager     = 1'b0;
    words_sent   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lone last words under the reset variant: empty, bytes past the count,
    // full last word with its extra padding word, oversized count
    push_word('1, 4'd0, 1'b1);
    push_word('1, 4'd7, 1'b1);
    push_word(64'h0011_2233_4455_6677, 4'd8, 1'b1);
    push_word('0, 4'd15, 1'b1);
    push_word(64'h0123_4567_89ab_cdef, 4'd1, 1'b1);
    // short and oversized counts on words that are not the last
    push_word('1, 4'd3, 1'b0);
    push_word('0, 4'd8, 1'b0);
    push_word(64'hfedc_ba98_7654_3210, 4'd4, 1'b1);
    push_word(64'ha5a5_a5a5_a5a5_a5a5, 4'd15, 1'b0);
    push_word(64'h5a5a_5a5a_5a5a_5a5a, 4'd9, 1'b1);
    in_valid_i <= 1'b0;

    set_variant(VARIANT_HASH);
    push_word(64'hdead_beef_0bad_f00d, 4'd5, 1'b1);
    in_valid_i <= 1'b0;
    set_variant(VARIANT_HASHA);
    push_word('1, 4'd8, 1'b0);
    push_word(64'h8000_0000_0000_0001, 4'd2, 1'b1);
    in_valid_i <= 1'b0;
    set_variant(VARIANT_SPARE);
    push_word(64'h0f0f_0f0f_f0f0_f0f0, 4'd6, 1'b1);
    in_valid_i <= 1'b0;

    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      case (phase)
        0:       code = VARIANT_HASHA;
        1:       code = VARIANT_HASH256;
        default: code = 2'($urandom_range(0, 3));
      endcase
      set_variant(code);
      tx_eager = ($urandom_range(0, 3) == 0);
      msgs     = $urandom_range(3, 6);
      // fill the block while the digest side is held off
      if (phase == 1) begin
        hold_go  = 1'b1;
        tx_eager = 1'b1;
        msgs     = 8;
      end
      repeat (msgs) random_message();
      in_valid_i <= 1'b0;
      phase++;
    end

    wait_all_digests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/asch_pkg.sv
design/asch_front.sv
design/asch_queue.sv
design/asch_back.sv
design/ascon_sponge_hash.sv
tb/ascon_sponge_hash_checker.sv
tb/ascon_sponge_hash_test.sv
